FILE: src/mbq_pkg.sv
`default_nettype none

package mbq_pkg;

	localparam int COEF_BITS     = 24;
	localparam int COEF_FRAC     = 20;
	localparam int DELAY_BITS    = 40;
	localparam int GUARD_BITS    = 8;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 3;
	localparam int COUNT_BITS    = 4;
	localparam int CHAN_OUT_BITS = 3;

	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_B0       = 3'd0,
		REG_B1       = 3'd1,
		REG_B2       = 3'd2,
		REG_A1       = 3'd3,
		REG_A2       = 3'd4,
		REG_CH_COUNT = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B0,
		ST_B1,
		ST_A1,
		ST_B2,
		ST_A2,
		ST_WR
	} state_t;

	typedef enum logic [2:0] {
		SEL_B0,
		SEL_B1,
		SEL_B2,
		SEL_A1,
		SEL_A2
	} coef_sel_t;

	typedef struct packed {
		coef_sel_t coef_sel;
		logic      mul_use_y;
		logic      ld_prod;
		logic      ld_y;
		logic      ld_acc;
		logic      acc_add_d2;
		logic      wr_d1;
		logic      wr_d2;
	} ctrl_t;

endpackage

`default_nettype wire

FILE: src/mbq_stream_if.sv
`default_nettype none

interface mbq_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface mbq_out_if #(
	parameter int SAMPLE_BITS = 24
);
	import mbq_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [CHAN_OUT_BITS-1:0]      channel_out;
	logic                          last_out;

	modport source (output valid, output sample_out, output channel_out, output last_out,
		input ready);
	modport sink   (input valid, input sample_out, input channel_out, input last_out,
		output ready);
endinterface

`default_nettype wire

FILE: src/multichannel_biquad_filter_top.sv
// Biquad IIR section (transposed direct form II) shared by up to MAX_CHANNELS
// interleaved audio channels, with two delay values kept for each channel.
// Input beats arrive on the samples channel (valid/ready); each carries one
// signed sample and an end-of-buffer flag. Each input beat gives exactly one
// output beat on the filtered channel, carrying the saturated result, the
// channel it belonged to and the end-of-buffer flag.
// The five products of an item go through one shared multiplier, one per
// cycle, in the states B0, B1, A1, B2 and A2, followed by a write-back
// state in which the result is loaded into the output register; the next
// beat can be accepted in that write-back state, not before. The input is
// not ready while an item is being worked on.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next item and then waits in write-back until that register
// is free. A channel counter advances per beat, wraps at the channel count
// and returns to channel 0 after a beat flagged as end of buffer.
// Reset loads the identity filter (b0 = 1.0, others 0), a channel count of
// one, clears all delay values and the channel counter. Writing the channel
// count register clears delays and counter in the same cycle.
`default_nettype none

module multichannel_biquad_filter_top #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [mbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [mbq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	mbq_in_if.sink                                    samples,
	mbq_out_if.source                                 filtered
);
	import mbq_pkg::*;

	localparam int PW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CMP_BITS = 6;
	localparam int EXTRA    = DELAY_BITS - SAMPLE_BITS - GUARD_BITS;
	localparam int PSHIFT   = COEF_FRAC - EXTRA;
	localparam int PRW      = COEF_BITS + SAMPLE_BITS;
	localparam int AW       = DELAY_BITS + 2;

	localparam longint HALF_P = 64'sd1 <<< (PSHIFT - 1);
	localparam longint HALF_Y = (EXTRA > 0) ? (64'sd1 <<< ((EXTRA > 0) ? EXTRA - 1 : 0))
		: 64'sd0;
	localparam logic signed [AW-1:0] Y_MAX = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);
	localparam logic signed [AW-1:0] D_MAX = AW'((64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] D_MIN = -D_MAX - AW'(1);
	localparam logic [CMP_BITS-1:0]  MAX_CH = CMP_BITS'(MAX_CHANNELS);

	// Configuration registers
	logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic                        clear_delays;

	// Sequencer and datapath state
	state_t                        state_q, state_d;
	ctrl_t                         ctrl;
	logic [PW-1:0]                 pos_q;
	logic [PW-1:0]                 ch_q;
	logic [CHAN_OUT_BITS-1:0]      ch_out_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                          last_q;
	logic signed [AW-1:0]          prod_q;
	logic signed [AW-1:0]          acc_q;
	logic signed [DELAY_BITS-1:0]  d1_q [MAX_CHANNELS];
	logic signed [DELAY_BITS-1:0]  d2_q [MAX_CHANNELS];

	// Output register
	logic                          out_v_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [CHAN_OUT_BITS-1:0]      out_ch_q;
	logic                          out_last_q;
	logic                          out_free;
	logic                          accept;

	// Channel counter arithmetic
	logic [CMP_BITS-1:0] cnt_ext, eff_cnt, pos_ext, c0_ext, inc_ext, next_ext;

	// Shared multiplier and its rounding
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_v;
	logic signed [PRW-1:0]         prod;
	logic signed [PRW:0]           prod_rs;
	logic signed [AW-1:0]          prod_rnd;

	// Output sample and delay update
	logic signed [AW-1:0] y_acc, y_sum, y_sh;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [AW-1:0] d_diff;
	logic signed [DELAY_BITS-1:0] d_sat;

	assign clear_delays = cfg_we && (cfg_reg_t'(cfg_index) == REG_CH_COUNT);
	assign out_free     = !out_v_q || filtered.ready;
	assign samples.ready = (state_q == ST_IDLE) || (state_q == ST_WR && out_free);
	assign accept       = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q    <= COEF_ONE;
			b1_q    <= '0;
			b2_q    <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			count_q <= COUNT_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_B0:       b0_q    <= cfg_data[COEF_BITS-1:0];
				REG_B1:       b1_q    <= cfg_data[COEF_BITS-1:0];
				REG_B2:       b2_q    <= cfg_data[COEF_BITS-1:0];
				REG_A1:       a1_q    <= cfg_data[COEF_BITS-1:0];
				REG_A2:       a2_q    <= cfg_data[COEF_BITS-1:0];
				REG_CH_COUNT: count_q <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// A count of zero behaves as one channel; a count beyond the storage is clipped.
	always_comb begin
		cnt_ext = CMP_BITS'(count_q);
		if (cnt_ext == '0) begin
			eff_cnt = CMP_BITS'(1);
		end else if (cnt_ext > MAX_CH) begin
			eff_cnt = MAX_CH;
		end else begin
			eff_cnt = cnt_ext;
		end
		pos_ext  = CMP_BITS'(pos_q);
		c0_ext   = (pos_ext >= eff_cnt) ? '0 : pos_ext;
		inc_ext  = c0_ext + CMP_BITS'(1);
		next_ext = (inc_ext >= eff_cnt || samples.last_in) ? '0 : inc_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (clear_delays) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= next_ext[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_B0;
			ST_B0:   state_d = ST_B1;
			ST_B1:   state_d = ST_A1;
			ST_A1:   state_d = ST_B2;
			ST_B2:   state_d = ST_A2;
			ST_A2:   state_d = ST_WR;
			ST_WR: begin
				if (out_free) begin
					state_d = accept ? ST_B0 : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{coef_sel: SEL_B0, mul_use_y: 1'b0, ld_prod: 1'b0, ld_y: 1'b0,
			ld_acc: 1'b0, acc_add_d2: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0};
		case (state_q)
			ST_B0: begin
				ctrl.coef_sel = SEL_B0;
				ctrl.ld_prod  = 1'b1;
			end
			ST_B1: begin
				ctrl.coef_sel = SEL_B1;
				ctrl.ld_prod  = 1'b1;
				ctrl.ld_y     = 1'b1;
			end
			ST_A1: begin
				ctrl.coef_sel   = SEL_A1;
				ctrl.mul_use_y  = 1'b1;
				ctrl.ld_prod    = 1'b1;
				ctrl.ld_acc     = 1'b1;
				ctrl.acc_add_d2 = 1'b1;
			end
			ST_B2: begin
				ctrl.coef_sel = SEL_B2;
				ctrl.ld_prod  = 1'b1;
				ctrl.wr_d1    = 1'b1;
			end
			ST_A2: begin
				ctrl.coef_sel  = SEL_A2;
				ctrl.mul_use_y = 1'b1;
				ctrl.ld_prod   = 1'b1;
				ctrl.ld_acc    = 1'b1;
			end
			ST_WR: ctrl.wr_d2 = 1'b1;
			default: begin
			end
		endcase
	end

	always_comb begin
		case (ctrl.coef_sel)
			SEL_B0:  mul_coef = b0_q;
			SEL_B1:  mul_coef = b1_q;
			SEL_B2:  mul_coef = b2_q;
			SEL_A1:  mul_coef = a1_q;
			SEL_A2:  mul_coef = a2_q;
			default: mul_coef = b0_q;
		endcase
	end

	assign mul_v    = ctrl.mul_use_y ? y_q : x_q;
	assign prod     = mul_coef * mul_v;
	// Every product is brought to the delay format, rounding half up.
	assign prod_rs  = $signed({prod[PRW-1], prod}) + $signed((PRW + 1)'(HALF_P));
	assign prod_rnd = AW'(prod_rs >>> PSHIFT);

	assign y_acc = prod_q + AW'(d1_q[ch_q]);
	assign y_sum = y_acc + AW'(HALF_Y);
	assign y_sh  = y_sum >>> EXTRA;

	always_comb begin
		if (y_sh > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_BITS-1:0];
		end else if (y_sh < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_sh[SAMPLE_BITS-1:0];
		end
	end

	// The feedback products are subtracted from the partial sum held in acc_q.
	assign d_diff = acc_q - prod_q;

	always_comb begin
		if (d_diff > D_MAX) begin
			d_sat = D_MAX[DELAY_BITS-1:0];
		end else if (d_diff < D_MIN) begin
			d_sat = D_MIN[DELAY_BITS-1:0];
		end else begin
			d_sat = d_diff[DELAY_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= samples.sample_in;
			last_q   <= samples.last_in;
			ch_q     <= c0_ext[PW-1:0];
			ch_out_q <= samples.last_in ? pos_ext[CHAN_OUT_BITS-1:0]
				: c0_ext[CHAN_OUT_BITS-1:0];
		end
		if (ctrl.ld_prod) begin
			prod_q <= prod_rnd;
		end
		if (ctrl.ld_y) begin
			y_q <= y_sat;
		end
		if (ctrl.ld_acc) begin
			acc_q <= prod_q + (ctrl.acc_add_d2 ? AW'(d2_q[ch_q]) : AW'(0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else if (clear_delays) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (ctrl.wr_d1) begin
				d1_q[ch_q] <= d_sat;
			end
			if (ctrl.wr_d2) begin
				d2_q[ch_q] <= d_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_WR && out_free) begin
			out_v_q <= 1'b1;
		end else if (filtered.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR && out_free) begin
			out_sample_q <= y_q;
			out_ch_q     <= ch_out_q;
			out_last_q   <= last_q;
		end
	end

	assign filtered.valid       = out_v_q;
	assign filtered.sample_out  = out_sample_q;
	assign filtered.channel_out = out_ch_q;
	assign filtered.last_out    = out_last_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_B0)
		else $error("accepted beat did not start the product sequence");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_ext < eff_cnt)
		else $error("channel counter beyond the channel count");

	a_out_from_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q) == ST_WR)
		else $error("output register loaded outside write-back");

	a_wr_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && out_free) |=> out_v_q)
		else $error("write-back did not present a result");
`endif

endmodule

`default_nettype wire

FILE: test/multichannel_biquad_filter_top_test.sv
`timescale 1ns / 100ps

module multichannel_biquad_filter_top_test;
	import mbq_pkg::*;

	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_BITS  = 24;
	localparam int EXTRA_FRAC   = DELAY_BITS - SAMPLE_BITS - GUARD_BITS;
	localparam int PROD_SHIFT   = COEF_FRAC - EXTRA_FRAC;
	localparam int PHASES       = 12;
	localparam int PHASE_BEATS  = 117;

	localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 24'sh7FFFFF;
	localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 24'sh800000;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
	// Indexes with no register behind them.
	localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_OUT_BITS-1:0]      channel;
		logic                          last;
	} filtered_beat_t;

	class biquad_scoreboard;
		logic signed [COEF_BITS-1:0]  b0, b1, b2, a1, a2;
		logic [COUNT_BITS-1:0]        chan_count;
		logic signed [DELAY_BITS-1:0] delay_one [MAX_CHANNELS];
		logic signed [DELAY_BITS-1:0] delay_two [MAX_CHANNELS];
		logic [CHAN_OUT_BITS-1:0]     position;
		filtered_beat_t               filtered_due [$];
		int                           failures;

		function new();
			b0 = COEF_ONE;
			b1 = '0;
			b2 = '0;
			a1 = '0;
			a2 = '0;
			chan_count = COUNT_BITS'(1);
			failures = 0;
			clear_delays();
		endfunction

		function void clear_delays();
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				delay_one[i] = '0;
				delay_two[i] = '0;
			end
			position = '0;
		endfunction

		function int active_channels();
			if (chan_count == 0)
				return 1;
			if (chan_count > MAX_CHANNELS)
				return MAX_CHANNELS;
			return int'(chan_count);
		endfunction

		// Exact Q3.20 by Q0.23 product, rounded half up into the delay format.
		function longint scaled_product(logic signed [COEF_BITS-1:0] coef,
				logic signed [SAMPLE_BITS-1:0] v);
			longint p;
			p = longint'(coef) * longint'(v);
			return (p + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] index,
				logic [CFG_DATA_BITS-1:0] data);
			case (index)
				REG_B0: b0 = data;
				REG_B1: b1 = data;
				REG_B2: b2 = data;
				REG_A1: a1 = data;
				REG_A2: a2 = data;
				REG_CH_COUNT: begin
					chan_count = data[COUNT_BITS-1:0];
					clear_delays();
				end
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SAMPLE_BITS-1:0] x, logic last);
			int                            count;
			int                            c;
			longint                        acc;
			longint                        d1;
			longint                        d2;
			logic signed [SAMPLE_BITS-1:0] y;
			filtered_beat_t                beat;
			count = active_channels();
			c = int'(position);
			if (c >= count)
				c = 0;
			acc = scaled_product(b0, x) + longint'(delay_one[c]);
			y = SAMPLE_BITS'(clamp((acc + (longint'(1) << (EXTRA_FRAC - 1))) >>> EXTRA_FRAC,
				SAMPLE_BITS));
			// The feedback products use the saturated output sample.
			d1 = clamp(scaled_product(b1, x) - scaled_product(a1, y)
				+ longint'(delay_two[c]), DELAY_BITS);
			d2 = clamp(scaled_product(b2, x) - scaled_product(a2, y), DELAY_BITS);
			delay_one[c] = DELAY_BITS'(d1);
			delay_two[c] = DELAY_BITS'(d2);
			beat.sample = y;
			beat.channel = last ? position : CHAN_OUT_BITS'(c);
			beat.last = last;
			filtered_due.push_back(beat);
			position = (c + 1 >= count || last) ? '0 : CHAN_OUT_BITS'(c + 1);
		endfunction

		function void check_filtered(logic signed [SAMPLE_BITS-1:0] sample,
				logic [CHAN_OUT_BITS-1:0] channel, logic last);
			filtered_beat_t want;
			if (filtered_due.size() == 0) begin
				$error("filtered beat with nothing outstanding: sample_out %0d", sample);
				failures++;
				return;
			end
			want = filtered_due.pop_front();
			if (sample !== want.sample) begin
				$error("sample_out: expected %0d, got %0d", want.sample, sample);
				failures++;
			end
			if (channel !== want.channel) begin
				$error("channel_out: expected %0d, got %0d", want.channel, channel);
				failures++;
			end
			if (last !== want.last) begin
				$error("last_out: expected %0d, got %0d", want.last, last);
				failures++;
			end
		endfunction

		function int outstanding();
			return filtered_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	mbq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
	mbq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) filtered ();

	multichannel_biquad_filter_top #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.samples  (samples),
		.filtered (filtered)
	);

	biquad_scoreboard sb = new();
	int  burst_left = 1;
	logic no_gaps = 1'b0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && samples.valid && samples.ready)
			sb.take_sample(samples.sample_in, samples.last_in);
		if (arst_n && filtered.valid && filtered.ready)
			sb.check_filtered(filtered.sample_out, filtered.channel_out, filtered.last_out);
	end

	// The receiver stalls on a pattern of its own, renewed once all of its bits have been used.
	initial begin
		logic [31:0] ready_pattern;
		filtered.ready = 1'b0;
		forever begin
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = $urandom;
				2: ready_pattern = $urandom | $urandom;
				default: ready_pattern = ($urandom & $urandom & $urandom) | 32'h1;
			endcase
			for (int i = 0; i < 32; i++) begin
				@(negedge clk);
				filtered.ready <= ready_pattern[i];
			end
		end
	end

	initial begin
		#1000000;
		$display("multichannel_biquad_filter_top_test: errors");
		$finish;
	end

	task automatic send_beat(logic signed [SAMPLE_BITS-1:0] s, logic l);
		@(negedge clk);
		samples.valid <= 1'b1;
		samples.sample_in <= s;
		samples.last_in <= l;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			int gap;
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk);
				samples.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		samples.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_BITS-1:0] index,
			logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		sb.write_reg(index, data);
		@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3: return CFG_DATA_BITS'(int'($urandom_range(0, 2 * COEF_ONE)) - int'(COEF_ONE));
			default: return CFG_DATA_BITS'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int  sent;
		int  len;
		int  chans;
		logic [CFG_DATA_BITS-1:0] count_word;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples.valid = 1'b0;
		samples.sample_in = '0;
		samples.last_in = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Identity filter, single channel: extremes pass straight through.
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b1);
		send_beat('0, 1'b0);
		send_beat(SAMPLE_BITS'(-1), 1'b0);
		send_beat(SAMPLE_BITS'(1), 1'b1);
		drain();

		// Extreme coefficients drive the output into saturation; the spare
		// indexes must leave everything alone.
		write_register(REG_B0, COEF_MAX);
		write_register(REG_B1, COEF_MIN);
		write_register(REG_B2, COEF_MAX);
		write_register(REG_A1, COEF_MIN);
		write_register(REG_A2, COEF_MAX);
		write_register(REG_CH_COUNT, CFG_DATA_BITS'(MAX_CHANNELS));
		write_register(IDX_SPARE_LO, '1);
		write_register(IDX_SPARE_HI, '0);
		end_writes();
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		send_beat(SAMPLE_MAX, 1'b0);
		// End of buffer part way through a frame sends the counter back to 0.
		send_beat(SAMPLE_MIN, 1'b1);
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		drain();

		// A channel count of zero behaves as one.
		write_register(REG_B0, COEF_ONE);
		write_register(REG_CH_COUNT, 24'hFFFFF0);
		end_writes();
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		send_beat(SAMPLE_BITS'(1), 1'b0);
		drain();

		// A count above the channel limit behaves as the limit.
		write_register(REG_CH_COUNT, 24'hABCDEF);
		end_writes();
		send_beat(SAMPLE_MAX, 1'b0);
		send_beat(SAMPLE_BITS'(-1), 1'b0);
		send_beat(SAMPLE_MIN, 1'b0);
		send_beat(SAMPLE_BITS'(1), 1'b0);
		send_beat('0, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase == 0 || $urandom_range(0, 1))
				write_register(REG_B0, pick_coef());
			if (phase == 0 || $urandom_range(0, 1))
				write_register(REG_B1, pick_coef());
			if (phase == 0 || $urandom_range(0, 1))
				write_register(REG_B2, pick_coef());
			if (phase == 0 || $urandom_range(0, 1))
				write_register(REG_A1, pick_coef());
			if (phase == 0 || $urandom_range(0, 1))
				write_register(REG_A2, pick_coef());
			if (phase == 0 || $urandom_range(0, 1)) begin
				count_word = CFG_DATA_BITS'($urandom);
				if ($urandom_range(0, 3) != 0)
					count_word[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(1, MAX_CHANNELS));
				write_register(REG_CH_COUNT, count_word);
			end
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
					CFG_DATA_BITS'($urandom));
			end_writes();
			no_gaps = (phase % 4 == 3);
			chans = sb.active_channels();
			sent = 0;
			// Mostly whole-frame buffers, with odd lengths and stray end flags mixed in.
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 3) != 0)
					len = chans * $urandom_range(1, 6);
				else
					len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					send_beat(pick_sample(), (i == len - 1) || ($urandom_range(0, 29) == 0));
				sent += len;
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.failures == 0)
			$display("multichannel_biquad_filter_top_test: clean");
		else
			$display("multichannel_biquad_filter_top_test: errors");
		$finish;
	end

endmodule
